// ===== sv/fvld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fvld_pkg;

  // structural characters of a form body
  localparam logic [7:0] ChrPercent = 8'h25;  // '%'
  localparam logic [7:0] ChrEquals  = 8'h3d;  // '='
  localparam logic [7:0] ChrAmp     = 8'h26;  // '&'

  // hex digits still owed after a percent sign
  localparam logic [1:0] HexDigitsOwed = 2'd2;

  // class of one byte, handed from the classifier to the state logic
  typedef struct packed {
    logic is_form;     // alphanumeric or accepted punctuation
    logic is_hex;      // 0-9, A-F, a-f
    logic is_percent;
    logic is_equals;
    logic is_amp;
  } byte_class_t;

endpackage

`default_nettype wire

// ===== sv/fvld_class.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fvld_class
  import fvld_pkg::*;
(
  input  var logic [7:0]  data_byte_i,
  output byte_class_t     class_o
);

  logic is_digit;
  logic is_upper;
  logic is_lower;
  logic is_punct;

  assign is_digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign is_upper = (data_byte_i >= 8'h41) && (data_byte_i <= 8'h5a);
  assign is_lower = (data_byte_i >= 8'h61) && (data_byte_i <= 8'h7a);

  // accepted punctuation: % + = & - _ . ~ : / ? # [ ] @ ! $ ' ( ) * , ;
  always_comb begin
    unique case (data_byte_i)
      8'h25, 8'h2b, 8'h3d, 8'h26, 8'h2d, 8'h5f, 8'h2e, 8'h7e,
      8'h3a, 8'h2f, 8'h3f, 8'h23, 8'h5b, 8'h5d, 8'h40, 8'h21,
      8'h24, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2c, 8'h3b: is_punct = 1'b1;
      default: is_punct = 1'b0;
    endcase
  end

  always_comb begin
    class_o.is_form    = is_digit || is_upper || is_lower || is_punct;
    class_o.is_hex     = is_digit ||
                         ((data_byte_i >= 8'h41) && (data_byte_i <= 8'h46)) ||
                         ((data_byte_i >= 8'h61) && (data_byte_i <= 8'h66));
    class_o.is_percent = (data_byte_i == ChrPercent);
    class_o.is_equals  = (data_byte_i == ChrEquals);
    class_o.is_amp     = (data_byte_i == ChrAmp);
  end

endmodule

`default_nettype wire

// ===== sv/fvld_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fvld_state
  import fvld_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        step_i,      // one item moves through this cycle
  input  var logic        has_byte_i,
  input  var logic        last_byte_i,
  input  var byte_class_t class_i,
  output logic            verdict_o    // body verdict including this item's byte
);

  logic       expect_key_q, expect_key_d;
  logic       seen_equals_q, seen_equals_d;
  logic       key_nonempty_q, key_nonempty_d;
  logic [1:0] hex_pending_q, hex_pending_d;
  logic       seen_any_q, seen_any_d;
  logic       failed_q, failed_d;

  // state after taking the byte, before the end-of-body clear
  always_comb begin
    expect_key_d   = expect_key_q;
    seen_equals_d  = seen_equals_q;
    key_nonempty_d = key_nonempty_q;
    hex_pending_d  = hex_pending_q;
    seen_any_d     = seen_any_q;
    failed_d       = failed_q;
    if (has_byte_i) begin
      seen_any_d = 1'b1;
      if (!failed_q) begin
        if (hex_pending_q != 2'd0) begin
          if (!class_i.is_hex) begin
            failed_d = 1'b1;
          end else begin
            hex_pending_d = hex_pending_q - 2'd1;
          end
        end else if (!class_i.is_form) begin
          failed_d = 1'b1;
        end else if (class_i.is_percent) begin
          hex_pending_d = HexDigitsOwed;
        end else if (class_i.is_equals) begin
          if (!expect_key_q || seen_equals_q || !key_nonempty_q) begin
            failed_d = 1'b1;
          end else begin
            expect_key_d  = 1'b0;
            seen_equals_d = 1'b1;
          end
        end else if (class_i.is_amp) begin
          // a leading '&' is tolerated
          if (expect_key_q && seen_any_q) begin
            failed_d = 1'b1;
          end else begin
            expect_key_d   = 1'b1;
            seen_equals_d  = 1'b0;
            key_nonempty_d = 1'b0;
          end
        end else if (expect_key_q) begin
          key_nonempty_d = 1'b1;
        end
      end
    end
  end

  assign verdict_o = !failed_d && (hex_pending_d == 2'd0) && !(expect_key_d && seen_any_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_key_q   <= 1'b1;
      seen_equals_q  <= 1'b0;
      key_nonempty_q <= 1'b0;
      hex_pending_q  <= 2'd0;
      seen_any_q     <= 1'b0;
      failed_q       <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        expect_key_q   <= 1'b1;
        seen_equals_q  <= 1'b0;
        key_nonempty_q <= 1'b0;
        hex_pending_q  <= 2'd0;
        seen_any_q     <= 1'b0;
        failed_q       <= 1'b0;
      end else begin
        expect_key_q   <= expect_key_d;
        seen_equals_q  <= seen_equals_d;
        key_nonempty_q <= key_nonempty_d;
        hex_pending_q  <= hex_pending_d;
        seen_any_q     <= seen_any_d;
        failed_q       <= failed_d;
      end
    end
  end

  a_hex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_pending_q != 2'd3)
    else $error("escape counter out of range");

  a_equals_ends_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_equals_q |-> !expect_key_q)
    else $error("equals seen while key still expected");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> expect_key_q && !seen_any_q && !failed_q &&
      hex_pending_q == 2'd0 && !seen_equals_q && !key_nonempty_q)
    else $error("state not cleared after end of body");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(step_i && last_byte_i) |=> failed_q)
    else $error("failure flag dropped inside a body");

endmodule

`default_nettype wire

// ===== sv/url_encoded_form_validator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// form-urlencoded syntax checker
// input channel: one transfer per body byte (data_byte_i, has_byte_i, last_byte_i)
//   qualified by in_valid_i / in_stall_o; has_byte_i low carries no byte, which
//   lets an empty body be closed with last_byte_i alone
// output channel: one transfer per body (body_valid_o) on out_valid_o / out_stall_i,
//   produced only for the input transfer marked last_byte_i
// result path: the input transfer that closes the body passes the input register,
//   then the result register
// throughput: one byte per cycle; the classifier and the state update both sit
//   between the input register and the result register
// a stalled result register blocks only a byte marked last; other bytes keep
//   flowing through the checker while the verdict waits to be taken
// reset: empty pipeline, checker state at start of body, no result pending

module url_encoded_form_validator_core
  import fvld_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  // input channel
  input  var logic       in_valid_i,
  output logic           in_stall_o,
  input  var logic [7:0] data_byte_i,
  input  var logic       has_byte_i,
  input  var logic       last_byte_i,
  // output channel
  output logic           out_valid_o,
  input  var logic       out_stall_i,
  output logic           body_valid_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_has_q;
  logic       s1_last_q;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       body_valid_q;

  logic        s1_adv;
  logic        in_fire;
  logic        verdict;
  byte_class_t byte_class;

  // the staged item moves unless it closes a body and the result slot is held
  assign s1_adv     = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_has_q  <= has_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_adv && s1_last_q) begin
      body_valid_q <= verdict;
    end
  end

  fvld_class u_class (
    .data_byte_i (s1_byte_q),
    .class_o     (byte_class)
  );

  fvld_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .has_byte_i  (s1_has_q),
    .last_byte_i (s1_last_q),
    .class_i     (byte_class),
    .verdict_o   (verdict)
  );

  assign out_valid_o  = out_valid_q;
  assign body_valid_o = body_valid_q;

endmodule

`default_nettype wire

// ===== tb/url_encoded_form_validator_core_tb.sv =====
`timescale 1ns / 1ps

module url_encoded_form_validator_core_tb;
  import fvld_pkg::*;

  localparam int RandomItems = 1700;
  localparam int CycleLimit  = 400000;
  localparam int HoldOffLen  = 400;   // long receiver hold-off, in cycles
  localparam int DrainCycles = 8;     // idle time after the last verdict is taken, before the run ends

  // one directed transfer; verdict is only meaningful when typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       typed;
    logic       verdict;
  } form_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       has_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       body_valid_o;

  // predicted checker state
  bit         want_key;
  bit         got_equals;
  bit         key_has_char;
  logic [1:0] hex_owed;
  bit         body_started;
  bit         body_bad;

  logic       verdicts_due[$];
  logic [7:0] body_bytes[$];
  int         mismatches;
  int         verdicts_taken;
  int         items_sent;
  int unsigned cycle_count;
  form_row_t  directed_rows[0:23];

  string punct_chars = "+-_.~:/?#[]@!$'()*,;";
  string alnum_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  string hex_chars   = "0123456789ABCDEFabcdef";

  url_encoded_form_validator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .body_valid_o(body_valid_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // byte classes and the checker state update
  // ---------------------------------------------------------------------------

  function automatic bit is_alnum_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_hex_digit(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  function automatic bit is_form_char(input logic [7:0] b);
    int i;
    if (is_alnum_char(b) || b == ChrPercent || b == ChrEquals || b == ChrAmp) begin
      return 1'b1;
    end
    for (i = 0; i < punct_chars.len(); i++) begin
      if (b == punct_chars[i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void clear_form_state();
    want_key     = 1'b1;
    got_equals   = 1'b0;
    key_has_char = 1'b0;
    hex_owed     = 2'd0;
    body_started = 1'b0;
    body_bad     = 1'b0;
  endfunction

  // advance the predicted state by one transfer; a transfer marked last yields a verdict
  function automatic void form_absorb(input logic [7:0] d, input logic has, input logic last,
                                      output bit verdict_due, output bit verdict);
    bit first;
    first       = !body_started;
    verdict_due = 1'b0;
    verdict     = 1'b0;
    if (has) begin
      body_started = 1'b1;
      if (!body_bad) begin
        if (hex_owed != 2'd0) begin
          // inside an escape only hex digits are allowed
          if (!is_hex_digit(d)) body_bad = 1'b1;
          else hex_owed = hex_owed - 2'd1;
        end else if (!is_form_char(d)) begin
          body_bad = 1'b1;
        end else if (d == ChrPercent) begin
          hex_owed = HexDigitsOwed;
        end else if (d == ChrEquals) begin
          if (!want_key || got_equals || !key_has_char) begin
            body_bad = 1'b1;
          end else begin
            want_key   = 1'b0;
            got_equals = 1'b1;
          end
        end else if (d == ChrAmp) begin
          // a leading ampersand is tolerated, any other one needs a finished pair
          if (want_key && !first) begin
            body_bad = 1'b1;
          end else begin
            want_key     = 1'b1;
            got_equals   = 1'b0;
            key_has_char = 1'b0;
          end
        end else if (want_key) begin
          key_has_char = 1'b1;
        end
      end
    end
    if (last) begin
      verdict_due = 1'b1;
      verdict     = !body_bad && hex_owed == 2'd0 && !(want_key && body_started);
      clear_form_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 2) == 0) begin
      return punct_chars[$urandom_range(0, punct_chars.len() - 1)];
    end
    return alnum_chars[$urandom_range(0, alnum_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] structural_char();
    case ($urandom_range(0, 2))
      0: return ChrPercent;
      1: return ChrEquals;
      default: return ChrAmp;
    endcase
  endfunction

  // one plain character or a full percent escape
  function automatic void push_token();
    if ($urandom_range(0, 4) == 0) begin
      body_bytes.push_back(ChrPercent);
      body_bytes.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      body_bytes.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
    end else begin
      body_bytes.push_back(plain_char());
    end
  endfunction

  // mostly well-formed key=value lists, some broken by one edit, some pure noise
  function automatic void build_body();
    int kind;
    int pairs;
    int p;
    int pos;
    kind = $urandom_range(0, 9);
    body_bytes.delete();
    if (kind == 0) begin
      repeat ($urandom_range(0, 8)) body_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 15) == 0) return;  // empty body
    if ($urandom_range(0, 9) == 0) body_bytes.push_back(ChrAmp);
    pairs = $urandom_range(1, 4);
    for (p = 0; p < pairs; p++) begin
      if (p > 0) body_bytes.push_back(ChrAmp);
      body_bytes.push_back(plain_char());
      repeat ($urandom_range(0, 3)) push_token();
      body_bytes.push_back(ChrEquals);
      repeat ($urandom_range(0, 5)) push_token();
    end
    if (kind >= 8) begin
      pos = $urandom_range(0, body_bytes.size() - 1);
      case ($urandom_range(0, 3))
        0: body_bytes[pos] = 8'($urandom_range(0, 255));
        1: body_bytes.delete(pos);
        2: body_bytes.insert(pos, structural_char());
        default: body_bytes.push_back(structural_char());
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [7:0] d, input logic has, input logic last,
                           input logic typed, input logic typed_verdict, input bit no_gaps);
    int gap;
    bit due;
    bit v;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    has_byte_i  <= has;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer taken at this edge
    form_absorb(d, has, last, due, v);
    if (due) verdicts_due.push_back(typed ? typed_verdict : logic'(v));
    if (has || last) items_sent++;
  endtask

  // the last byte is either marked itself or closed by a byteless transfer
  task automatic drive_body(input bit no_gaps);
    int n;
    int i;
    bit split_end;
    n = body_bytes.size();
    split_end = (n == 0) || ($urandom_range(0, 4) == 0);
    for (i = 0; i < n; i++) begin
      if (!no_gaps && $urandom_range(0, 11) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0, no_gaps);
      end
      send_item(body_bytes[i], 1'b1, !split_end && i == n - 1, 1'b0, 1'b0, no_gaps);
    end
    if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0, no_gaps);
  endtask

  task automatic wait_for_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic expd, input logic got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected %0b, got %0b at cycle %0d", what, expd, got, cycle_count);
    end
  endtask

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      verdicts_taken++;
      if (verdicts_due.size() == 0) begin
        note_mismatch("verdict with no body pending", 1'bx, body_valid_o);
      end else begin
        want = verdicts_due.pop_front();
        if (body_valid_o !== want) note_mismatch("body_valid_o", want, body_valid_o);
      end
    end
  end

  // receiver: random stalls, runs without stalls, and one long hold-off so the
  // result register fills and the input side backs up
  initial begin
    bit held_off;
    int n;
    held_off    = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_off && verdicts_taken >= 60) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOffLen) @(posedge clk_i);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int r;
    int bodies;
    int random_target;
    bit no_gaps;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    has_byte_i   = 1'b0;
    last_byte_i  = 1'b0;
    cycle_count  = 0;
    mismatches   = 0;
    verdicts_taken = 0;
    items_sent   = 0;
    clear_form_state();

    directed_rows = '{
      // empty body, then a transfer that carries nothing
      '{8'h00,      1'b0, 1'b1, 1'b1, 1'b1},
      '{8'ha5,      1'b0, 1'b0, 1'b0, 1'b0},
      // simplest pair
      '{"a",        1'b1, 1'b0, 1'b0, 1'b0},
      '{ChrEquals,  1'b1, 1'b0, 1'b0, 1'b0},
      '{"b",        1'b1, 1'b1, 1'b1, 1'b1},
      // NUL and the top byte value
      '{8'h00,      1'b1, 1'b1, 1'b1, 1'b0},
      '{8'hff,      1'b1, 1'b1, 1'b1, 1'b0},
      // leading ampersand and an escape in the value
      '{ChrAmp,     1'b1, 1'b0, 1'b0, 1'b0},
      '{"k",        1'b1, 1'b0, 1'b0, 1'b0},
      '{ChrEquals,  1'b1, 1'b0, 1'b0, 1'b0},
      '{ChrPercent, 1'b1, 1'b0, 1'b0, 1'b0},
      '{"A",        1'b1, 1'b0, 1'b0, 1'b0},
      '{"f",        1'b1, 1'b1, 1'b0, 1'b0},
      // body ends inside an escape
      '{ChrPercent, 1'b1, 1'b1, 1'b1, 1'b0},
      // body ends while a key is expected
      '{"x",        1'b1, 1'b1, 1'b1, 1'b0},
      // equals sign with an empty key
      '{ChrEquals,  1'b1, 1'b1, 1'b1, 1'b0},
      // ampersand before the pair is finished
      '{"a",        1'b1, 1'b0, 1'b0, 1'b0},
      '{ChrAmp,     1'b1, 1'b1, 1'b1, 1'b0},
      // bad escape digit, later bytes ignored
      '{ChrPercent, 1'b1, 1'b0, 1'b0, 1'b0},
      '{"g",        1'b1, 1'b0, 1'b0, 1'b0},
      '{"z",        1'b1, 1'b1, 1'b1, 1'b0},
      // closing mark without a byte, data ignored
      '{"q",        1'b1, 1'b0, 1'b0, 1'b0},
      '{ChrEquals,  1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hff,      1'b0, 1'b1, 1'b1, 1'b1}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < 24; r++) begin
      send_item(directed_rows[r].data, directed_rows[r].has, directed_rows[r].last,
                directed_rows[r].typed, directed_rows[r].verdict, 1'b0);
    end

    bodies = 0;
    random_target = items_sent + RandomItems;
    while (items_sent < random_target) begin
      bodies++;
      // sender pauses until every verdict is back
      if (bodies % 120 == 40) wait_for_verdicts();
      no_gaps = ($urandom_range(0, 3) == 0);
      build_body();
      drive_body(no_gaps);
    end

    wait_for_verdicts();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
